FILE: rtl/tilt_pkg.sv
package tilt_pkg;

  localparam int ACCEL_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int CORDIC_RUN   = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

  localparam int SUM_W   = 24;
  localparam int OPND_W  = SUM_W + 1;
  localparam int ANG_W   = 26;
  localparam int XY_W    = OPND_W + 1 + CORDIC_STEPS + 2;
  localparam int STEP_W  = 5;
  localparam int ANGLE_W = 16;

  localparam logic signed [ANG_W-1:0] RIGHT_ANGLE = ANG_W'(90 * 25600);
  localparam logic [15:0] BATT_SCALE = 16'd55550;
  localparam logic [7:0]  WINDOW_RESET = 8'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_B,
    ST_SQRT,
    ST_ROLL_GO,
    ST_ROLL_WAIT,
    ST_PITCH_GO,
    ST_PITCH_WAIT,
    ST_DIV,
    ST_DONE
  } tilt_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [OPND_W-1:0] y;
    logic signed [OPND_W-1:0] x;
  } cordic_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [ANGLE_W-1:0] angle;
  } cordic_rsp_t;

  // atan(2^-i) in 1/256 of a hundredth of a degree
  function automatic logic [20:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [20:0] v;
    unique case (i)
      5'd0:  v = 21'd1152000;
      5'd1:  v = 21'd680065;
      5'd2:  v = 21'd359328;
      5'd3:  v = 21'd182400;
      5'd4:  v = 21'd91554;
      5'd5:  v = 21'd45822;
      5'd6:  v = 21'd22916;
      5'd7:  v = 21'd11459;
      5'd8:  v = 21'd5730;
      5'd9:  v = 21'd2865;
      5'd10: v = 21'd1432;
      5'd11: v = 21'd716;
      5'd12: v = 21'd358;
      5'd13: v = 21'd179;
      5'd14: v = 21'd90;
      5'd15: v = 21'd45;
      5'd16: v = 21'd22;
      5'd17: v = 21'd11;
      5'd18: v = 21'd6;
      5'd19: v = 21'd3;
      5'd20: v = 21'd1;
      5'd21: v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/tilt_cordic.sv
module tilt_cordic import tilt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);

  logic signed [XY_W-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic signed [ANG_W-1:0] ang_r, ang_nxt, tab, rnd;
  logic [STEP_W-1:0]       step_r;
  logic                    busy_r, done_r, zero_r;
  logic signed [OPND_W:0]  px, py;
  logic signed [ANG_W-1:0] ang0;

  // turn a left-half vector by +-90 degrees
  always_comb begin
    px   = (OPND_W+1)'(req.x);
    py   = (OPND_W+1)'(req.y);
    ang0 = '0;
    if (req.x < 0) begin
      if (req.y >= 0) begin
        px   = (OPND_W+1)'(req.y);
        py   = -(OPND_W+1)'(req.x);
        ang0 = RIGHT_ANGLE;
      end else begin
        px   = -(OPND_W+1)'(req.y);
        py   = (OPND_W+1)'(req.x);
        ang0 = -RIGHT_ANGLE;
      end
    end
  end

  always_comb begin
    tab = ANG_W'(atan_entry(step_r));
    if (y_r > 0) begin
      x_nxt   = x_r + (y_r >>> step_r);
      y_nxt   = y_r - (x_r >>> step_r);
      ang_nxt = ang_r + tab;
    end else begin
      x_nxt   = x_r - (y_r >>> step_r);
      y_nxt   = y_r + (x_r >>> step_r);
      ang_nxt = ang_r - tab;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_W'(CORDIC_RUN - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      zero_r <= (req.x == '0) && (req.y == '0);
      x_r    <= {{(XY_W-OPND_W-1-CORDIC_STEPS){px[OPND_W]}}, px, {CORDIC_STEPS{1'b0}}};
      y_r    <= {{(XY_W-OPND_W-1-CORDIC_STEPS){py[OPND_W]}}, py, {CORDIC_STEPS{1'b0}}};
      ang_r  <= ang0;
      step_r <= '0;
    end else if (busy_r) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      ang_r  <= ang_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  assign rnd       = ang_r + ANG_W'(128);
  assign rsp.done  = done_r;
  assign rsp.angle = zero_r ? '0 : ANGLE_W'(rnd >>> 8);

endmodule

FILE: rtl/tilt_angle_from_accel_average_unit.sv
// tilt angle unit: averaged roll / pitch and battery voltage
//
// input channel (in_valid / in_ready) takes one item per accepted beat: an
// accelerometer triple, a 10-bit battery adc sample and a tare request.
// items are summed; an item that is not the last of its window is taken and
// in_ready stays high. the last item of a window (sample count reaches or
// exceeds window_length) starts the result computation, during which
// in_ready is low: the shared multiplier forms y^2, z^2 and the battery
// product, then follow the square root, two cordic runs on the shared
// cordic unit (start plus 16 steps plus hand-back each), restoring
// division and the load of the output register; in_ready comes back in
// the same cycle that out_valid rises.
// the result (roll, pitch in 0.01 deg minus tare offsets, battery mV) goes
// to an output register with out_valid / out_ready; while it waits there
// the block takes new items again. a finished result that finds the output
// register still full holds the block until the receiver takes the old one.
// a pending tare loads the window's raw angles as new offsets as that result
// is handed to the output register; that result still uses the old offsets.
// cfg channel writes window_length (reset 100), always ready; write it only
// while idle. synchronous active-low reset clears sums, offsets and tare.
module tilt_angle_from_accel_average_unit import tilt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [9:0]         in_battery_sample,
  input  logic               in_tare_request,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic [13:0]        out_battery_millivolts,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_window_length
);

  tilt_state_t state_r, state_nxt;

  // window accumulators
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic [17:0]             bsum_r;
  logic [7:0]              count_r, count_nxt, window_r;
  logic                    tare_r;
  logic signed [15:0]      roll_off_r;
  logic signed [14:0]      pitch_off_r;

  logic signed [ACCEL_BITS-1:0] ax, ay, az;

  // shared multiplier
  logic [23:0] mul_a, mul_b, mag_y, mag_z;
  logic [47:0] mul_r, acc_r;

  // square root
  logic [47:0] sq_v_r;
  logic [26:0] rem_r, rem_s, trial;
  logic [23:0] root_r;
  logic [4:0]  sq_cnt_r;
  logic        sq_last;

  // divider
  logic [19:0] den;
  logic [34:0] num_r;
  logic [20:0] d2_r;
  logic [21:0] drem_r, drem_s;
  logic [13:0] q_r;
  logic [5:0]  div_cnt_r;
  logic        div_last;

  logic signed [ANGLE_W-1:0] roll_raw_r, pitch_raw_r;
  logic signed [17:0]        roll_diff;
  logic signed [16:0]        pitch_diff;

  cordic_req_t cor_req;
  cordic_rsp_t cor_rsp;

  logic in_fire, window_end, out_load, out_valid_r;

  assign ax = in_accel_x[ACCEL_BITS-1:0];
  assign ay = in_accel_y[ACCEL_BITS-1:0];
  assign az = in_accel_z[ACCEL_BITS-1:0];

  assign sum_x_nxt  = sum_x_r + SUM_W'(ax);
  assign sum_y_nxt  = sum_y_r + SUM_W'(ay);
  assign sum_z_nxt  = sum_z_r + SUM_W'(az);
  assign count_nxt  = count_r + 1'b1;
  assign in_fire    = in_valid && in_ready;
  assign window_end = count_nxt >= window_r;

  assign sq_last  = sq_cnt_r == 5'd23;
  assign div_last = div_cnt_r == 6'd34;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_valid && window_end) state_nxt = ST_SQ_Y;
      ST_SQ_Y:       state_nxt = ST_SQ_Z;
      ST_SQ_Z:       state_nxt = ST_SQ_B;
      ST_SQ_B:       state_nxt = ST_SQRT;
      ST_SQRT:       if (sq_last) state_nxt = ST_ROLL_GO;
      ST_ROLL_GO:    state_nxt = ST_ROLL_WAIT;
      ST_ROLL_WAIT:  if (cor_rsp.done) state_nxt = ST_PITCH_GO;
      ST_PITCH_GO:   state_nxt = ST_PITCH_WAIT;
      ST_PITCH_WAIT: if (cor_rsp.done) state_nxt = ST_DIV;
      ST_DIV:        if (div_last) state_nxt = ST_DONE;
      ST_DONE:       if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    cor_req.start = 1'b0;
    cor_req.y     = OPND_W'(sum_y_r);
    cor_req.x     = OPND_W'(sum_z_r);
    unique case (state_r)
      ST_IDLE:     in_ready = 1'b1;
      ST_ROLL_GO:  cor_req.start = 1'b1;
      ST_PITCH_GO: begin
        cor_req.start = 1'b1;
        cor_req.y     = -OPND_W'(sum_x_r);
        cor_req.x     = OPND_W'({1'b0, root_r});
      end
      ST_DONE:     out_load = !out_valid_r || out_ready;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  tilt_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .rsp   (cor_rsp)
  );

  // accumulators, offsets and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      bsum_r      <= '0;
      count_r     <= '0;
      tare_r      <= 1'b0;
      roll_off_r  <= '0;
      pitch_off_r <= '0;
      window_r    <= WINDOW_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_window_length;
      end
      if (in_fire) begin
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
        sum_z_r <= sum_z_nxt;
        bsum_r  <= bsum_r + 18'(in_battery_sample);
        count_r <= count_nxt;
        if (in_tare_request) begin
          tare_r <= 1'b1;
        end
      end else if (out_load) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
        sum_z_r <= '0;
        bsum_r  <= '0;
        count_r <= '0;
        if (tare_r) begin
          roll_off_r  <= roll_raw_r;
          pitch_off_r <= 15'(pitch_raw_r);
          tare_r      <= 1'b0;
        end
      end
    end
  end

  // multiplier operands: y^2, z^2, then battery sum times scale
  assign mag_y = sum_y_r[SUM_W-1] ? 24'(-sum_y_r) : 24'(sum_y_r);
  assign mag_z = sum_z_r[SUM_W-1] ? 24'(-sum_z_r) : 24'(sum_z_r);

  always_comb begin
    unique case (state_r)
      ST_SQ_Y: begin
        mul_a = mag_y;
        mul_b = mag_y;
      end
      ST_SQ_Z: begin
        mul_a = mag_z;
        mul_b = mag_z;
      end
      default: begin
        mul_a = 24'(bsum_r);
        mul_b = 24'(BATT_SCALE);
      end
    endcase
  end

  assign rem_s  = {rem_r[24:0], sq_v_r[47:46]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign den    = (20'(count_r) << 11) + (20'(count_r) << 7);
  assign drem_s = {drem_r[20:0], num_r[34]};

  // datapath of the sequencer
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_SQ_Y: mul_r <= mul_a * mul_b;
      ST_SQ_Z: begin
        mul_r <= mul_a * mul_b;
        acc_r <= mul_r;
      end
      ST_SQ_B: begin
        mul_r    <= mul_a * mul_b;
        sq_v_r   <= acc_r + mul_r;
        rem_r    <= '0;
        root_r   <= '0;
        sq_cnt_r <= '0;
      end
      ST_SQRT: begin
        sq_v_r   <= sq_v_r << 2;
        sq_cnt_r <= sq_cnt_r + 1'b1;
        if (rem_s >= trial) begin
          rem_r  <= rem_s - trial;
          root_r <= {root_r[22:0], 1'b1};
        end else begin
          rem_r  <= rem_s;
          root_r <= {root_r[22:0], 1'b0};
        end
      end
      ST_ROLL_WAIT: if (cor_rsp.done) roll_raw_r <= cor_rsp.angle;
      ST_PITCH_WAIT: begin
        if (cor_rsp.done) begin
          pitch_raw_r <= cor_rsp.angle;
          // rounding half up: (2*prod + 2*den) / (4*den) == (prod + den) / (2*den)
          num_r     <= mul_r[34:0] + 35'(den);
          d2_r      <= {den, 1'b0};
          drem_r    <= '0;
          q_r       <= '0;
          div_cnt_r <= '0;
        end
      end
      ST_DIV: begin
        num_r     <= num_r << 1;
        div_cnt_r <= div_cnt_r + 1'b1;
        if (drem_s >= 22'(d2_r)) begin
          drem_r <= drem_s - 22'(d2_r);
          q_r    <= {q_r[12:0], 1'b1};
        end else begin
          drem_r <= drem_s;
          q_r    <= {q_r[12:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign roll_diff  = 18'(roll_raw_r) - 18'(roll_off_r);
  assign pitch_diff = 17'(pitch_raw_r) - 17'(pitch_off_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_roll_angle         <= 17'(roll_diff);
      out_pitch_angle        <= 16'(pitch_diff);
      out_battery_millivolts <= q_r;
    end
  end

  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

endmodule

FILE: rtl/tilt_checker.sv
module tilt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_roll_angle,
  input logic [15:0] out_pitch_angle,
  input logic [13:0] out_battery_millivolts
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_roll_angle)
      && $stable(out_pitch_angle) && $stable(out_battery_millivolts))
    else $error("result changed while stalled");

  // a new result only comes out of the busy computation
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without computation");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind tilt_angle_from_accel_average_unit tilt_checker u_tilt_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_roll_angle         (out_roll_angle),
  .out_pitch_angle        (out_pitch_angle),
  .out_battery_millivolts (out_battery_millivolts)
);

FILE: tb/sv/tilt_angle_from_accel_average_unit_tb.sv
`timescale 1ns / 1ps

module tilt_angle_from_accel_average_unit_tb import tilt_pkg::*; ();

  // per-step arctangent, 1/256 of a hundredth of a degree
  function automatic longint atan_step(input int i);
    case (i)
      0: return 1152000;  1: return 680065;  2: return 359328;  3: return 182400;
      4: return 91554;    5: return 45822;   6: return 22916;   7: return 11459;
      8: return 5730;     9: return 2865;    10: return 1432;   11: return 716;
      12: return 358;     13: return 179;    14: return 90;     15: return 45;
      16: return 22;      17: return 11;     18: return 6;      19: return 3;
      20: return 1;       21: return 1;
      default: return 0;
    endcase
  endfunction

  class tilt_scoreboard;
    int unsigned win_len;
    longint acc_x, acc_y, acc_z, batt_acc;
    int unsigned n_samples;
    int roll_zero, pitch_zero;
    bit zero_armed;
    bit [16:0] roll_q[$];
    bit [15:0] pitch_q[$];
    bit [13:0] mv_q[$];
    int errors, n_results;

    function new();
      win_len = WINDOW_RESET;
      acc_x = 0; acc_y = 0; acc_z = 0; batt_acc = 0;
      n_samples = 0; roll_zero = 0; pitch_zero = 0; zero_armed = 0;
      errors = 0; n_results = 0;
    endfunction

    function longint floor_shift(input longint v, input int s);
      return v >>> s;
    endfunction

    function longint int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // vectoring cordic, hundredths of a degree
    function int angle_of(input longint yy, input longint xx);
      longint ang, t, nx, ny;
      ang = 0;
      if (xx == 0 && yy == 0) return 0;
      if (xx < 0) begin
        if (yy >= 0) begin
          t = xx; xx = yy; yy = -t; ang = 90 * 25600;
        end else begin
          t = xx; xx = -yy; yy = t; ang = -90 * 25600;
        end
      end
      xx = xx <<< CORDIC_STEPS;
      yy = yy <<< CORDIC_STEPS;
      for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++) begin
        if (yy > 0) begin
          nx = xx + floor_shift(yy, i); ny = yy - floor_shift(xx, i);
          ang += atan_step(i);
        end else begin
          nx = xx - floor_shift(yy, i); ny = yy + floor_shift(xx, i);
          ang -= atan_step(i);
        end
        xx = nx; yy = ny;
      end
      return int'(floor_shift(ang + 128, 8));
    endfunction

    function void note_item(input logic signed [15:0] ax, ay, az,
                            input logic [9:0] bs, input logic tr);
      int roll_raw, pitch_raw;
      longint hyp;
      longint unsigned den, mv;
      acc_x += ax; acc_y += ay; acc_z += az; batt_acc += bs;
      if (tr) zero_armed = 1;
      n_samples++;
      if (n_samples < win_len) return;
      hyp = int_sqrt(acc_y * acc_y + acc_z * acc_z);
      roll_raw = angle_of(acc_y, acc_z);
      pitch_raw = angle_of(-acc_x, hyp);
      den = 2176 * n_samples;
      mv = (batt_acc * 27775 * 2 + den) / (2 * den);
      roll_q.push_back(17'(roll_raw - roll_zero));
      pitch_q.push_back(16'(pitch_raw - pitch_zero));
      mv_q.push_back(14'(mv));
      if (zero_armed) begin
        roll_zero = roll_raw; pitch_zero = pitch_raw; zero_armed = 0;
      end
      acc_x = 0; acc_y = 0; acc_z = 0; batt_acc = 0; n_samples = 0;
    endfunction

    function void check_result(input logic [16:0] r, input logic [15:0] p,
                               input logic [13:0] m);
      bit [16:0] er;
      bit [15:0] ep;
      bit [13:0] em;
      n_results++;
      if (roll_q.size() == 0) begin
        $display("%0t: unexpected result roll %0d pitch %0d mv %0d", $time,
                 $signed(r), $signed(p), m);
        errors++;
        return;
      end
      er = roll_q.pop_front(); ep = pitch_q.pop_front(); em = mv_q.pop_front();
      if (r !== er) begin
        $display("%0t: roll expected %0d actual %0d", $time, $signed(er), $signed(r));
        errors++;
      end
      if (p !== ep) begin
        $display("%0t: pitch expected %0d actual %0d", $time, $signed(ep), $signed(p));
        errors++;
      end
      if (m !== em) begin
        $display("%0t: millivolts expected %0d actual %0d", $time, em, m);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic signed [15:0] in_accel_x, in_accel_y, in_accel_z;
  logic [9:0] in_battery_sample;
  logic in_tare_request;
  logic out_valid, out_ready;
  logic signed [16:0] out_roll_angle;
  logic signed [15:0] out_pitch_angle;
  logic [13:0] out_battery_millivolts;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_window_length;

  tilt_angle_from_accel_average_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_battery_sample(in_battery_sample), .in_tare_request(in_tare_request),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_angle(out_roll_angle), .out_pitch_angle(out_pitch_angle),
    .out_battery_millivolts(out_battery_millivolts),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_window_length(cfg_window_length)
  );

  tilt_scoreboard sb;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned n_items;
  longint cycle_count;

  localparam longint CYCLE_LIMIT = 2_000_000;
  // result path: multiply, sqrt, two cordic runs, divide
  localparam int RESULT_LATENCY = 200;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog on cycles
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall, compare at the rising edge
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_roll_angle, out_pitch_angle, out_battery_millivolts);
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one item through the input handshake, noted when accepted
  task automatic send_item(input logic signed [15:0] ax, ay, az,
                           input logic [9:0] bs, input logic tr);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1;
    in_accel_x = ax; in_accel_y = ay; in_accel_z = az;
    in_battery_sample = bs; in_tare_request = tr;
    do @(posedge clk); while (!in_ready);
    sb.note_item(ax, ay, az, bs, tr);
    n_items++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain_results();
    while (sb.roll_q.size() != 0) @(negedge clk);
    repeat (RESULT_LATENCY) @(negedge clk);
  endtask

  // window change only once idle; partial windows carry over on purpose
  task automatic write_window(input logic [7:0] len);
    drain_results();
    cfg_valid = 1;
    cfg_window_length = len;
    do @(posedge clk); while (!cfg_ready);
    sb.win_len = len;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_random(input int mode);
    logic signed [15:0] ax, ay, az;
    logic [9:0] bs;
    case (mode)
      0: begin  // small tilts around gravity on z
        ax = $signed(16'($urandom_range(4000))) - 2000;
        ay = $signed(16'($urandom_range(4000))) - 2000;
        az = 16'sd16384 + $signed(16'($urandom_range(600))) - 300;
      end
      1: begin  // near-zero vectors, hits the origin and axes
        ax = $signed(16'($urandom_range(4))) - 2;
        ay = $signed(16'($urandom_range(4))) - 2;
        az = $signed(16'($urandom_range(4))) - 2;
      end
      default: begin
        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
      end
    endcase
    bs = 10'($urandom);
    send_item(ax, ay, az, bs, ($urandom_range(19) == 0));
  endtask

  task automatic random_phase(input int count, input int unsigned si, ri);
    send_idle_pct = si; recv_idle_pct = ri;
    for (int i = 0; i < count; i++) send_random($urandom_range(3));
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0; in_accel_x = 0; in_accel_y = 0; in_accel_z = 0;
    in_battery_sample = 0; in_tare_request = 0;
    cfg_valid = 0; cfg_window_length = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    n_items = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;

    // directed: one-sample windows over the corners
    write_window(8'd1);
    send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 10'h3ff, 1'b0);
    send_item(-16'sh8000, -16'sh8000, -16'sh8000, 10'h000, 1'b0);
    send_item(16'sd0, 16'sd0, 16'sd0, 10'd512, 1'b0);       // zero vector
    send_item(16'sd0, 16'sd0, -16'sd100, 10'd1, 1'b0);      // z negative, y zero
    send_item(16'sd0, -16'sd5, -16'sd100, 10'd2, 1'b0);     // both negative
    send_item(16'sd100, 16'sd0, 16'sd0, 10'd3, 1'b0);       // pitch only
    send_item(-16'sd100, 16'sd50, 16'sd0, 10'h2aa, 1'b0);
    send_item(16'sd0, 16'sd300, 16'sd16384, 10'h155, 1'b1); // tare
    send_item(16'sd10, 16'sd300, 16'sd16384, 10'd700, 1'b0);
    send_item(16'sd0, 16'sd0, 16'sd0, 10'd700, 1'b1);       // tare on zero
    // zero window length acts as one
    write_window(8'd0);
    send_item(16'sh5555, -16'sh2aab, 16'sh1234, 10'h3ff, 1'b0);
    send_item(16'sh0f0f, 16'sh70f0, -16'sh0f10, 10'h0ff, 1'b0);
    // full window of maxima; tare on the last item counts
    write_window(8'd255);
    for (int i = 0; i < 255; i++)
      send_item(-16'sh8000, -16'sh8000, 16'sh7fff, 10'h3ff, i == 254);
    write_window(8'd3);
    send_item(16'sd1, 16'sd2, 16'sd3, 10'd4, 1'b0);
    send_item(16'sd1, 16'sd2, 16'sd3, 10'd4, 1'b0);
    // shorten mid-window: ends at the next item
    write_window(8'd2);
    send_item(16'sd1, 16'sd2, 16'sd3, 10'd4, 1'b0);
    send_item(16'sd1, 16'sd2, 16'sd3, 10'd4, 1'b0);
    send_item(16'sd1, 16'sd2, 16'sd3, 10'd4, 1'b0);

    // random, mostly short windows so results are frequent
    write_window(8'd4);
    random_phase(200, 12, 52);
    write_window(8'd1);
    random_phase(200, 52, 12);
    write_window(8'($urandom_range(2, 7)));
    random_phase(110, 0, 0);
    write_window(8'd100);
    random_phase(70, 0, 0);
    drain_results();

    $display("%0d items in %0d results, window lengths 0 to 255, tare and zero vectors",
             n_items, sb.n_results);
    if (sb.errors == 0 && sb.roll_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.roll_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
